/* rtl/poc_pkg.sv */
// Shared types, constants and helpers of the passivity observer/controller.
`timescale 1ns / 1ps
package poc_pkg;

  localparam logic signed [47:0] E_MAX     = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] E_MIN     = 48'sh8000_0000_0000;
  localparam logic [63:0]        VSQ_FLOOR = 64'd4295;

  localparam logic [1:0] REG_LOOP_PERIOD   = 2'd0;
  localparam logic [1:0] REG_MAX_DAMPING   = 2'd1;
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd2;
  localparam logic [1:0] REG_AXIS_MASK     = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_EMUL, S_EGET, S_VMUL, S_VACC, S_DLO, S_DHI, S_DCMB, S_DIV,
    S_AMUL, S_AGET, S_SMUL, S_SACC, S_CLO, S_CHI, S_CCMB, S_TRIM, S_TCHK, S_OUT
  } state_e;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [30:0] quo;
  } div_res_t;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    if (x[48] != x[47]) begin
      return x[48] ? E_MIN : E_MAX;
    end
    return x[47:0];
  endfunction

endpackage

/* rtl/passivity_observer_controller_unit.sv */
// Top level of the passivity observer/controller: sequencer, state and APB registers.
`timescale 1ns / 1ps
// One tick is taken per transfer and the block stalls its input until the tick's result
// sits in the output register. A tick with a negative observer uses the single shared
// multiplier (14 products) and the 32-step divider that forms alpha, which stops early
// when alpha saturates; a tick with a non-negative observer runs the trim loop, which
// reads the window memory one entry at a time until the window is short enough or it
// reaches an entry it keeps. An output stall can hold a tick in its output state. The
// window memory holds WINDOW_DEPTH 48-bit energy samples and needs no clearing after
// reset.
module passivity_observer_controller_unit #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               restart_i,
  input  logic signed [31:0] power_robot_i,
  input  logic signed [31:0] power_feedback_i,
  input  logic signed [31:0] power_controller_in_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] damp_x_o,
  output logic signed [31:0] damp_y_o,
  output logic signed [31:0] damp_z_o,
  output logic [30:0]        alpha_o,
  output logic               active_o,
  output logic               overflow_o
);
  import poc_pkg::*;

  localparam int AW   = $clog2(WINDOW_DEPTH);
  localparam int CW   = $clog2(WINDOW_DEPTH + 1);
  localparam int IW   = CW + 1;
  localparam int CMPW = (CW > 9) ? CW : 9;

  state_e state_q, state_d;

  logic [31:0] dt_q;
  logic [30:0] maxd_q;
  logic [8:0]  wlen_q;
  logic [2:0]  mask_q;

  logic signed [47:0] obs_q, obs_d;
  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] odx_q, ody_q, odz_q;
  logic [30:0]        oalpha_q;
  logic               oactive_q, oovf_q;

  logic [32:0]        pabs_q, pabs_d;
  logic               pneg_q, pneg_d;
  logic signed [31:0] v_q [3];
  logic signed [31:0] v_d [3];
  logic signed [31:0] d_q [3];
  logic signed [31:0] d_d [3];
  logic [31:0]        dabs_q, dabs_d;
  logic [1:0]         ax_q, ax_d;
  logic [63:0]        vsq_q, vsq_d;
  logic [63:0]        s_q, s_d;
  logic [63:0]        lo_q, lo_d;
  logic [30:0]        alpha_q, alpha_d;
  logic               active_q, active_d, ovf_q, ovf_d;
  logic signed [47:0] e_q, e_d;
  logic [AW-1:0]      newest_q, newest_d;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;

  logic        div_start;
  logic [95:0] div_num, div_den;
  div_res_t    div_res;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [47:0]   ram_wdata, ram_rdata;

  logic               cfg_wr;
  logic signed [33:0] psum;
  logic [31:0]        vabs;
  logic [48:0]        eq;
  logic signed [47:0] e_new, obs_sum, front, add;
  logic [AW-1:0]      head_adj;
  logic [CW-1:0]      cnt_adj;
  logic [IW-1:0]      idx_sum;
  logic [95:0]        wide;
  logic [46:0]        amag;
  logic [31:0]        dmag;
  logic               out_load;

  poc_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  poc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .res_o  (div_res)
  );

  poc_ram #(.WIDTH(48), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_LOOP_PERIOD:   prdata = dt_q;
      REG_MAX_DAMPING:   prdata = {1'b0, maxd_q};
      REG_WINDOW_LENGTH: prdata = {23'd0, wlen_q};
      REG_AXIS_MASK:     prdata = {29'd0, mask_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= 32'd66;
      maxd_q <= 31'd65536;
      wlen_q <= 9'd64;
      mask_q <= 3'd7;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOOP_PERIOD:   dt_q   <= pwdata;
        REG_MAX_DAMPING:   maxd_q <= pwdata[30:0];
        REG_WINDOW_LENGTH: wlen_q <= pwdata[8:0];
        REG_AXIS_MASK:     mask_q <= pwdata[2:0];
        default:           ;
      endcase
    end
  end

  assign vabs = v_q[ax_q][31] ? 32'(-v_q[ax_q]) : 32'(v_q[ax_q]);
  assign psum = 34'(power_controller_in_i) - 34'(power_feedback_i) - 34'(power_robot_i);
  assign wide = {mul_p[63:0], 32'd0} + {32'd0, lo_q};
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    obs_d     = obs_q;
    head_d    = head_q;
    count_d   = count_q;
    pabs_d    = pabs_q;
    pneg_d    = pneg_q;
    v_d       = v_q;
    d_d       = d_q;
    dabs_d    = dabs_q;
    ax_d      = ax_q;
    vsq_d     = vsq_q;
    s_d       = s_q;
    lo_d      = lo_q;
    alpha_d   = alpha_q;
    active_d  = active_q;
    ovf_d     = ovf_q;
    e_d       = e_q;
    newest_d  = newest_q;
    mul_a     = {1'b0, vabs};
    mul_b     = dt_q;
    div_start = 1'b0;
    div_num   = {-obs_q, 48'd0};
    div_den   = wide;
    ram_we    = 1'b0;
    ram_addr  = head_q;
    ram_wdata = e_q;
    eq        = mul_p[64:16];
    e_new     = '0;
    obs_sum   = '0;
    front     = ram_rdata;
    add       = '0;
    head_adj  = head_q;
    cnt_adj   = count_q;
    idx_sum   = '0;
    amag      = mul_p[62:16];
    dmag      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pneg_d   = psum[33];
          pabs_d   = psum[33] ? 33'(-psum) : 33'(psum);
          v_d[0]   = vel_x_i;
          v_d[1]   = vel_y_i;
          v_d[2]   = vel_z_i;
          d_d[0]   = '0;
          d_d[1]   = '0;
          d_d[2]   = '0;
          alpha_d  = '0;
          active_d = 1'b0;
          ovf_d    = 1'b0;
          vsq_d    = '0;
          s_d      = '0;
          ax_d     = '0;
          if (restart_i) begin
            obs_d   = '0;
            head_d  = '0;
            count_d = '0;
          end
          state_d = S_EMUL;
        end
      end
      S_EMUL: begin
        mul_a   = pabs_q;
        state_d = S_EGET;
      end
      S_EGET: begin
        if (pneg_q) begin
          e_new = (eq >= 49'h0_8000_0000_0000) ? E_MIN : -$signed(eq[47:0]);
        end else begin
          e_new = (eq > 49'h0_7FFF_FFFF_FFFF) ? E_MAX : $signed(eq[47:0]);
        end
        if (count_q == CW'(WINDOW_DEPTH)) begin
          head_adj = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);
          cnt_adj  = CW'(WINDOW_DEPTH - 1);
          ovf_d    = 1'b1;
        end
        idx_sum = IW'(head_adj) + IW'(cnt_adj);
        if (idx_sum >= IW'(WINDOW_DEPTH)) begin
          idx_sum = idx_sum - IW'(WINDOW_DEPTH);
        end
        newest_d  = idx_sum[AW-1:0];
        ram_we    = 1'b1;
        ram_addr  = idx_sum[AW-1:0];
        ram_wdata = e_new;
        e_d       = e_new;
        head_d    = head_adj;
        count_d   = cnt_adj + CW'(1);
        obs_sum   = sat48({obs_q[47], obs_q} + {e_new[47], e_new});
        obs_d     = obs_sum;
        if (obs_sum[47]) begin
          active_d = 1'b1;
          state_d  = S_VMUL;
        end else begin
          state_d = S_TRIM;
        end
      end
      S_VMUL: begin
        mul_b   = vabs;
        state_d = S_VACC;
      end
      S_VACC: begin
        vsq_d = vsq_q + mul_p[63:0];
        if (ax_q == 2'd2) begin
          if (vsq_d < VSQ_FLOOR) begin
            vsq_d = VSQ_FLOOR;
          end
          ax_d    = '0;
          state_d = S_DLO;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_VMUL;
        end
      end
      S_DLO: begin
        mul_a   = {1'b0, vsq_q[31:0]};
        state_d = S_DHI;
      end
      S_DHI: begin
        lo_d    = mul_p[63:0];
        mul_a   = {1'b0, vsq_q[63:32]};
        state_d = S_DCMB;
      end
      S_DCMB: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          if (div_res.sat || (div_res.quo > maxd_q)) begin
            alpha_d = maxd_q;
          end else begin
            alpha_d = div_res.quo;
          end
          state_d = S_AMUL;
        end
      end
      S_AMUL: begin
        mul_a   = {2'd0, alpha_q};
        mul_b   = vabs;
        state_d = S_AGET;
      end
      S_AGET: begin
        if (!mask_q[ax_q]) begin
          dmag      = '0;
          d_d[ax_q] = '0;
        end else if (v_q[ax_q][31]) begin
          dmag      = (amag > 47'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : amag[31:0];
          d_d[ax_q] = $signed(dmag);
        end else begin
          dmag      = (amag > 47'h0_8000_0000) ? 32'h8000_0000 : amag[31:0];
          d_d[ax_q] = -$signed(dmag);
        end
        dabs_d  = dmag;
        state_d = S_SMUL;
      end
      S_SMUL: begin
        mul_b   = dabs_q;
        state_d = S_SACC;
      end
      S_SACC: begin
        s_d = s_q + mul_p[63:0];
        if (ax_q == 2'd2) begin
          state_d = S_CLO;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_AMUL;
        end
      end
      S_CLO: begin
        mul_a   = {1'b0, s_q[31:0]};
        state_d = S_CHI;
      end
      S_CHI: begin
        lo_d    = mul_p[63:0];
        mul_a   = {1'b0, s_q[63:32]};
        state_d = S_CCMB;
      end
      S_CCMB: begin
        add       = (wide[95:79] != '0) ? E_MAX : $signed(wide[79:32]);
        obs_d     = sat48({obs_q[47], obs_q} + {1'b0, add});
        ram_we    = 1'b1;
        ram_addr  = newest_q;
        ram_wdata = sat48({e_q[47], e_q} + {1'b0, add});
        state_d   = S_OUT;
      end
      S_TRIM: begin
        ram_addr = head_q;
        if (CMPW'(count_q) > CMPW'(wlen_q)) begin
          state_d = S_TCHK;
        end else begin
          state_d = S_OUT;
        end
      end
      S_TCHK: begin
        if (obs_q > front) begin
          if (front > 48'sd0) begin
            obs_d = sat48({obs_q[47], obs_q} - {front[47], front});
          end
          head_d  = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);
          count_d = count_q - CW'(1);
          state_d = S_TRIM;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      obs_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      obs_q       <= obs_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pabs_q   <= pabs_d;
    pneg_q   <= pneg_d;
    v_q      <= v_d;
    d_q      <= d_d;
    dabs_q   <= dabs_d;
    ax_q     <= ax_d;
    vsq_q    <= vsq_d;
    s_q      <= s_d;
    lo_q     <= lo_d;
    alpha_q  <= alpha_d;
    active_q <= active_d;
    ovf_q    <= ovf_d;
    e_q      <= e_d;
    newest_q <= newest_d;
    if (out_load) begin
      odx_q     <= d_q[0];
      ody_q     <= d_q[1];
      odz_q     <= d_q[2];
      oalpha_q  <= alpha_q;
      oactive_q <= active_q;
      oovf_q    <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign damp_x_o    = odx_q;
  assign damp_y_o    = ody_q;
  assign damp_z_o    = odz_q;
  assign alpha_o     = oalpha_q;
  assign active_o    = oactive_q;
  assign overflow_o  = oovf_q;
endmodule

/* rtl/poc_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module poc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/poc_mul.sv */
// Shared unsigned 33x32 multiplier with registered product.
`timescale 1ns / 1ps
module poc_mul (
  input  logic        clk_i,
  input  logic [32:0] a_i,
  input  logic [31:0] b_i,
  output logic [64:0] p_o
);
  logic [64:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 65'(a_i) * 65'(b_i);
  end

  assign p_o = p_q;
endmodule

/* rtl/poc_div.sv */
// Restoring divider, one quotient bit per cycle, for the damping coefficient.
`timescale 1ns / 1ps
module poc_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [95:0]      num_i,
  input  logic [95:0]      den_i,
  output poc_pkg::div_res_t res_o
);
  logic         run_q, run_d, first_q, first_d, done_q, done_d, sat_q, sat_d;
  logic [4:0]   bit_q, bit_d;
  logic [95:0]  rem_q, rem_d;
  logic [126:0] dsh_q, dsh_d;
  logic [30:0]  quo_q, quo_d;
  logic         ge;

  assign ge = {31'd0, rem_q} >= dsh_q;

  always_comb begin
    run_d   = run_q;
    first_d = first_q;
    done_d  = 1'b0;
    sat_d   = sat_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    if (start_i) begin
      rem_d   = num_i;
      dsh_d   = {den_i, 31'd0};
      quo_d   = '0;
      sat_d   = 1'b0;
      first_d = 1'b1;
      bit_d   = 5'd30;
      if (den_i == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        sat_d  = 1'b1;
      end else begin
        run_d = 1'b1;
      end
    end else if (run_q) begin
      if (first_q) begin
        if (ge) begin
          run_d  = 1'b0;
          done_d = 1'b1;
          sat_d  = 1'b1;
        end else begin
          first_d = 1'b0;
          dsh_d   = dsh_q >> 1;
        end
      end else begin
        if (ge) begin
          rem_d        = rem_q - dsh_q[95:0];
          quo_d[bit_q] = 1'b1;
        end
        if (bit_q == 5'd0) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end else begin
          bit_d = bit_q - 5'd1;
          dsh_d = dsh_q >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    sat_q   <= sat_d;
    bit_q   <= bit_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.quo  = quo_q;
endmodule

/* rtl/poc_checker.sv */
// Port-level assertions for the passivity observer/controller, bound to the top level.
`timescale 1ns / 1ps
module poc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] damp_x_o,
  input logic signed [31:0] damp_y_o,
  input logic signed [31:0] damp_z_o,
  input logic [30:0]        alpha_o,
  input logic               active_o
);
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !active_o) |->
      (alpha_o == 31'd0 && damp_x_o == 32'sd0 && damp_y_o == 32'sd0 && damp_z_o == 32'sd0))
    else $error("inactive result carries damping");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again without processing");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_alpha_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(alpha_o) && $stable(damp_x_o)))
    else $error("stalled result changed");
endmodule

bind passivity_observer_controller_unit poc_checker u_poc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .damp_x_o   (damp_x_o),
  .damp_y_o   (damp_y_o),
  .damp_z_o   (damp_z_o),
  .alpha_o    (alpha_o),
  .active_o   (active_o)
);
